[sv/jl2d_pkg.sv]
`default_nettype none
package jl2d_pkg;

	localparam int unsigned GRID_N  = 64;
	localparam int unsigned CELL_W  = 24;
	localparam int unsigned SUM_W   = CELL_W + 2;
	localparam int unsigned ITER_W  = 16;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned COORD_W = $clog2(GRID_N + 2);
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CELL_W-1:0] RESIDUAL_RESET = CELL_W'(84);
	localparam logic [ITER_W-1:0] ITER_RESET     = ITER_W'(1000);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SOLVE = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESIDUAL = 1'b0,
		REG_ITER     = 1'b1
	} reg_idx_t;

	typedef logic [CELL_W-1:0] cell_t;

endpackage
`default_nettype wire

[sv/jacobi_laplace_2d_solver_unit.sv]
// channel  | handshake            | payload
// in       | in_valid / in_ready  | op, row, col, cell_value
// out      | out_valid / out_ready| read_value, sweeps_done, max_change, converged
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Write and no-op beats answer straight from the accept; a read passes through S_RD (registered bank read).
// A solve repeats sweeps until it converges or reaches the sweep limit; each sweep
// streams the whole grid once through the 2*(GRID_N+2)+1 cell line buffer.
// Reset clears control, limits and results only; the grid banks hold nothing until written.
// in_ready is low while a solve or read is in flight or a result is stalled.
`default_nettype none
module jacobi_laplace_2d_solver_unit import jl2d_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           op,
	input  wire logic [COORD_W-1:0]   row,
	input  wire logic [COORD_W-1:0]   col,
	input  wire logic [CELL_W-1:0]    cell_value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CELL_W-1:0]         read_value,
	output logic [COUNT_W-1:0]        sweeps_done,
	output logic [CELL_W-1:0]         max_change,
	output logic                      converged,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CELL_W-1:0]    cfg_data
);

	localparam int unsigned STRIDE = GRID_N + 2;
	localparam int unsigned NCELL  = STRIDE * STRIDE;
	localparam int unsigned TOTAL  = NCELL + STRIDE;
	localparam int unsigned AW     = $clog2(NCELL);
	localparam int unsigned KW     = $clog2(TOTAL + 1);
	localparam int unsigned RW     = $clog2(STRIDE);
	localparam int unsigned CHAIN  = 2 * STRIDE + 1;

	typedef enum logic [1:0] {S_IDLE, S_RD, S_SWEEP, S_EVAL} state_t;

	state_t state_q;
	logic   sel_q, out_valid_q, conv_q, rd_in_q;
	cell_t  res_lim_q, worst_q, maxch_q, rv_q;
	logic [ITER_W-1:0]  iter_lim_q;
	logic [COUNT_W-1:0] cnt_q, sweeps_q;
	logic [KW-1:0] k_q, k_s1, k_s2;
	logic v_s1, v_s2;
	logic [RW-1:0] cr_q, cc_q;
	logic [AW-1:0] ca_q;
	cell_t nv_s3, ov_s3;
	logic [AW-1:0] wa_s3;
	logic w_s3, last_s3;

	// input decode
	logic in_acc, in_range;
	logic [AW-1:0] in_addr;
	op_t in_op;
	assign in_op   = op_t'(op);
	assign in_acc  = in_valid && in_ready;
	assign in_range = (32'(row) <= STRIDE - 1) && (32'(col) <= STRIDE - 1);
	assign in_addr = AW'(32'(row) * STRIDE + 32'(col));
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	// banks
	cell_t rdata0, rdata1, rdata;
	logic [AW-1:0] raddr, waddr;
	cell_t wdata;
	logic wr_item, we0, we1;
	assign wr_item = in_acc && in_op == OP_WRITE && in_range;
	assign raddr = (state_q == S_SWEEP) ? k_q[AW-1:0] : in_addr;
	assign waddr = (state_q == S_SWEEP) ? wa_s3 : in_addr;
	assign wdata = (state_q == S_SWEEP) ? nv_s3 : cell_value;
	assign we0 = (wr_item && !sel_q) || (w_s3 && sel_q);
	assign we1 = (wr_item && sel_q) || (w_s3 && !sel_q);
	assign rdata = sel_q ? rdata1 : rdata0;

	jl2d_bank #(.DEPTH(NCELL), .AW(AW)) u_bank0 (
		.clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata0)
	);
	jl2d_bank #(.DEPTH(NCELL), .AW(AW)) u_bank1 (
		.clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata1)
	);

	// line buffer: tap i holds the element i places behind the newest
	cell_t tap [CHAIN];
	for (genvar i = 0; i < CHAIN; i++) begin : g_cell
		jl2d_cell u_cell (
			.clk(clk),
			.d  ((i == 0) ? rdata : tap[(i == 0) ? 0 : i - 1]),
			.q  (tap[i])
		);
	end

	logic live, interior, last_c;
	logic [SUM_W-1:0] nsum;
	cell_t centre, nv;
	assign live     = v_s2 && (k_s2 >= KW'(STRIDE));
	assign interior = cr_q != '0 && cr_q != RW'(STRIDE - 1)
		&& cc_q != '0 && cc_q != RW'(STRIDE - 1);
	assign centre = tap[STRIDE];
	assign nsum = SUM_W'(tap[0]) + SUM_W'(tap[2 * STRIDE])
		+ SUM_W'(tap[STRIDE - 1]) + SUM_W'(tap[STRIDE + 1]);
	assign nv = interior ? nsum[SUM_W-1:2] : centre;
	assign last_c = ca_q == AW'(NCELL - 1);

	cell_t diff;
	assign diff = (nv_s3 > ov_s3) ? nv_s3 - ov_s3 : ov_s3 - nv_s3;

	logic sweep_start;
	logic [COUNT_W-1:0] cnt_next;
	logic stop, conv_now;
	assign cnt_next = cnt_q + COUNT_W'(1);
	assign conv_now = worst_q <= res_lim_q;
	assign stop = conv_now || (cnt_next > COUNT_W'(iter_lim_q));
	assign sweep_start = (in_acc && in_op == OP_SOLVE) || (state_q == S_EVAL && !stop);

	// stream pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			w_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_SWEEP) && (k_q < KW'(TOTAL));
			v_s2 <= v_s1;
			w_s3 <= live;
		end
	end

	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		k_s2    <= k_s1;
		nv_s3   <= nv;
		ov_s3   <= centre;
		wa_s3   <= ca_q;
		last_s3 <= last_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			cr_q    <= '0;
			cc_q    <= '0;
			ca_q    <= '0;
			worst_q <= '0;
		end else if (sweep_start) begin
			k_q     <= '0;
			cr_q    <= '0;
			cc_q    <= '0;
			ca_q    <= '0;
			worst_q <= '0;
		end else begin
			if (state_q == S_SWEEP && k_q < KW'(TOTAL)) begin
				k_q <= k_q + KW'(1);
			end
			if (live) begin
				ca_q <= ca_q + AW'(1);
				if (cc_q == RW'(STRIDE - 1)) begin
					cc_q <= '0;
					cr_q <= cr_q + RW'(1);
				end else begin
					cc_q <= cc_q + RW'(1);
				end
			end
			if (w_s3 && diff > worst_q) begin
				worst_q <= diff;
			end
		end
	end

	// control, limits and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
			rv_q        <= '0;
			rd_in_q     <= 1'b0;
			cnt_q       <= '0;
			sweeps_q    <= '0;
			maxch_q     <= '0;
			conv_q      <= 1'b0;
			res_lim_q   <= RESIDUAL_RESET;
			iter_lim_q  <= ITER_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_RESIDUAL: res_lim_q  <= cfg_data;
					REG_ITER:     iter_lim_q <= cfg_data[ITER_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_op)
							OP_SOLVE: begin
								cnt_q   <= '0;
								state_q <= S_SWEEP;
							end
							OP_READ: begin
								rd_in_q <= in_range;
								state_q <= S_RD;
							end
							default: begin
								rv_q        <= '0;
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_RD: begin
					rv_q        <= rd_in_q ? rdata : '0;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SWEEP: begin
					if (w_s3 && last_s3) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					// new values now live in the other bank
					sel_q <= !sel_q;
					cnt_q <= cnt_next;
					if (stop) begin
						sweeps_q    <= cnt_next;
						maxch_q     <= worst_q;
						conv_q      <= conv_now;
						rv_q        <= '0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_SWEEP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = rv_q;
	assign sweeps_done = sweeps_q;
	assign max_change  = maxch_q;
	assign converged   = conv_q;

endmodule
`default_nettype wire

[sv/jl2d_bank.sv]
`default_nettype none
module jl2d_bank import jl2d_pkg::*; #(
	parameter int unsigned DEPTH = 4356,
	parameter int unsigned AW    = 13
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire cell_t         wdata,
	input  wire logic [AW-1:0] raddr,
	output cell_t              rdata
);

	cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[sv/jl2d_cell.sv]
`default_nettype none
module jl2d_cell import jl2d_pkg::*; (
	input  wire logic clk,
	input  wire cell_t d,
	output cell_t      q
);

	// one tap of the raster line buffer, moves every cycle
	always_ff @(posedge clk) begin
		q <= d;
	end

endmodule
`default_nettype wire

[sv/jl2d_checker.sv]
`default_nettype none
module jl2d_checker import jl2d_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [1:0]         op,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [CELL_W-1:0]  read_value
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value))
		else $error("result changed under stall");

	// no new beat while an undelivered result would be overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("input taken with result stalled");

	a_write_resp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_WRITE || op == OP_NOP) |=> out_valid)
		else $error("write beat without result");

	a_read_resp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_READ |=> !out_valid ##1 out_valid)
		else $error("read result timing");

	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_SOLVE |=> !in_ready)
		else $error("input taken during solve");

endmodule

bind jacobi_laplace_2d_solver_unit jl2d_checker u_jl2d_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .op(op),
	.out_valid(out_valid), .out_ready(out_ready), .read_value(read_value)
);
`default_nettype wire

[verif/jacobi_laplace_2d_solver_unit_tb.sv]
`default_nettype none
module jacobi_laplace_2d_solver_unit_tb;
	import jl2d_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GN = int'(GRID_N);
	localparam int ST = GN + 2;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		cell_t                rd;
		logic [COUNT_W-1:0]   sw;
		cell_t                mc;
		logic                 cv;
	} solver_result_t;

	class jacobi_scoreboard;
		cell_t               cells [ST*ST];
		cell_t               res_lim;
		logic [ITER_W-1:0]   iter_lim;
		logic [COUNT_W-1:0]  sweeps;
		cell_t               worst_last;
		logic                conv;
		solver_result_t      pending [$];
		int                  errors;

		function new();
			res_lim    = RESIDUAL_RESET;
			iter_lim   = ITER_RESET;
			sweeps     = '0;
			worst_last = '0;
			conv       = 1'b0;
			errors     = 0;
			foreach (cells[k]) cells[k] = '0;
		endfunction

		function void set_reg(reg_idx_t idx, cell_t data);
			if (idx == REG_RESIDUAL)
				res_lim = data;
			else
				iter_lim = data[ITER_W-1:0];
		endfunction

		function void relax();
			cell_t       fresh [GN*GN];
			int unsigned s, d, worst, count;
			count = 0;
			do begin
				worst = 0;
				for (int i = 1; i <= GN; i++)
					for (int j = 1; j <= GN; j++) begin
						s = 32'(cells[(i+1)*ST+j]) + 32'(cells[(i-1)*ST+j])
						  + 32'(cells[i*ST+j+1]) + 32'(cells[i*ST+j-1]);
						fresh[(i-1)*GN+j-1] = cell_t'(s >> 2);
					end
				for (int i = 1; i <= GN; i++)
					for (int j = 1; j <= GN; j++) begin
						s = 32'(fresh[(i-1)*GN+j-1]);
						d = 32'(cells[i*ST+j]);
						d = (s > d) ? s - d : d - s;
						if (d > worst) worst = d;
						cells[i*ST+j] = cell_t'(s);
					end
				count++;
			end while (!(worst <= 32'(res_lim) || count > 32'(iter_lim)));
			sweeps     = COUNT_W'(count);
			worst_last = cell_t'(worst);
			conv       = (worst <= 32'(res_lim));
		endfunction

		function void note_beat(logic [1:0] op, logic [COORD_W-1:0] r,
				logic [COORD_W-1:0] c, cell_t v);
			solver_result_t e;
			logic inb;
			inb  = (32'(r) <= ST-1) && (32'(c) <= ST-1);
			e.rd = '0;
			case (op_t'(op))
				OP_WRITE: if (inb) cells[r*ST+c] = v;
				OP_SOLVE: relax();
				OP_READ:  if (inb) e.rd = cells[r*ST+c];
				default: ;
			endcase
			e.sw = sweeps;
			e.mc = worst_last;
			e.cv = conv;
			pending.push_back(e);
		endfunction

		function void check_beat(cell_t rd, logic [COUNT_W-1:0] sw, cell_t mc, logic cv);
			solver_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat rd=%h sw=%0d mc=%h cv=%b",
					$time, rd, sw, mc, cv);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (rd !== e.rd) begin
				$display("%0t: read_value expected %h actual %h", $time, e.rd, rd);
				errors++;
			end
			if (sw !== e.sw) begin
				$display("%0t: sweeps_done expected %0d actual %0d", $time, e.sw, sw);
				errors++;
			end
			if (mc !== e.mc) begin
				$display("%0t: max_change expected %h actual %h", $time, e.mc, mc);
				errors++;
			end
			if (cv !== e.cv) begin
				$display("%0t: converged expected %b actual %b", $time, e.cv, cv);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           op = '0;
	logic [COORD_W-1:0]   row = '0;
	logic [COORD_W-1:0]   col = '0;
	cell_t                cell_value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	cell_t                read_value;
	logic [COUNT_W-1:0]   sweeps_done;
	cell_t                max_change;
	logic                 converged;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	cell_t                cfg_data = '0;

	logic hold_off = 1'b0;
	int   idle_cycles = 0;
	jacobi_scoreboard sb = new();

	jacobi_laplace_2d_solver_unit uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_beat(op, row, col, cell_value);
		if (out_valid && out_ready)
			sb.check_beat(read_value, sweeps_done, max_change, converged);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 15) == 0) return int'($urandom_range(10, 40));
		if ($urandom_range(0, 1) == 0) return 0;
		return int'($urandom_range(1, 3));
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready = 1'b0;
				repeat (500) @(negedge clk);
				hold_off = 1'b0;
			end else if ($urandom_range(0, 31) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(10, 60)) @(negedge clk);
			end else begin
				out_ready = ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic send(logic [1:0] o, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
			cell_t v, int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		op         = o;
		row        = r;
		col        = c;
		cell_value = v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(reg_idx_t idx, cell_t data);
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_limits(cell_t res, cell_t iter);
		write_reg(REG_RESIDUAL, res);
		write_reg(REG_ITER, iter);
	endtask

	task automatic random_item();
		int                  sel;
		logic [1:0]          o;
		logic [COORD_W-1:0]  r, c;
		sel = int'($urandom_range(0, 99));
		if (sel < 45)      o = OP_WRITE;
		else if (sel < 84) o = OP_READ;
		else if (sel < 96) o = OP_NOP;
		else               o = OP_SOLVE;
		if ($urandom_range(0, 9) == 0) begin
			r = COORD_W'($urandom_range(0, 127));
			c = COORD_W'($urandom_range(0, 127));
		end else begin
			r = COORD_W'($urandom_range(0, ST-1));
			c = COORD_W'($urandom_range(0, ST-1));
		end
		send(o, r, c, cell_t'($urandom()), pick_gap());
	endtask

	initial begin
		cell_t v;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every cell written before any solve; values kept at or below 1.0 so the
		// first solve converges in a single sweep even with a huge sweep budget
		for (int i = 0; i < ST; i++)
			for (int j = 0; j < ST; j++) begin
				case ($urandom_range(0, 9))
					0:       v = '0;
					1:       v = 24'd8388608;
					default: v = cell_t'($urandom_range(0, 8388608));
				endcase
				send(OP_WRITE, COORD_W'(i), COORD_W'(j), v,
					($urandom_range(0, 7) == 0) ? pick_gap() : 0);
			end

		set_limits(24'd8388608, 24'd65535);
		send(OP_SOLVE, 0, 0, 0, 0);
		send(OP_READ, 0, 0, 0, 0);
		send(OP_READ, COORD_W'(ST-1), COORD_W'(ST-1), 0, 1);
		send(OP_READ, 1, 1, 0, 0);
		// both stop conditions on the same sweep
		set_limits(24'd8388608, 24'd0);
		send(OP_SOLVE, 0, 0, 0, 0);
		send(OP_READ, 32, 32, 0, 0);
		set_limits(24'd0, 24'd2);
		send(OP_SOLVE, 0, 0, 0, 0);
		send(OP_NOP, 127, 127, 24'hFFFFFF, 0);
		send(OP_WRITE, 127, 127, 24'hFFFFFF, 0);
		send(OP_WRITE, 3, 66, 24'h123456, 0);
		send(OP_READ, 127, 0, 0, 0);
		send(OP_READ, 0, 66, 0, 2);
		send(OP_WRITE, 1, 1, 24'hFFFFFF, 0);
		send(OP_WRITE, COORD_W'(ST-1), 0, 24'hFFFFFF, 0);
		send(OP_READ, 1, 1, 0, 0);
		send(OP_READ, COORD_W'(ST-1), 0, 0, 0);
		send(OP_SOLVE, 0, 0, 0, 3);
		send(OP_READ, 1, 1, 0, 0);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0:       v = '0;
				1:       v = 24'd8388608;
				2:       v = cell_t'($urandom_range(0, 1000));
				default: v = cell_t'($urandom_range(0, 8388608));
			endcase
			set_limits(v, cell_t'($urandom_range(0, 3)));
			for (int k = 0; k < 100; k++) begin
				if (phase == 2 && k == 10) hold_off = 1'b1;
				random_item();
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
